// ===== rtl/core/keyed_context_store_lru_macros.svh =====
// assertion macros for the keyed context store
// each use names its own label; the enclosing module provides clk and rst_n
`ifndef KEYED_CONTEXT_STORE_LRU_MACROS_SVH
`define KEYED_CONTEXT_STORE_LRU_MACROS_SVH
`ifndef SYNTHESIS
`define KCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcs assertion failed");
`define KCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcs assertion failed");
`else
`define KCS_ASSERT_IMP(lbl, ante, cons)
`define KCS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/kcs_pkg.sv =====
`timescale 1ns / 1ps
package kcs_pkg;

  localparam int OP_W      = 3;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int STAMP_W   = 64;
  localparam int CNT_OUT_W = 6;
  localparam int LIMIT_W   = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd4;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_GET_ALL = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  // selection rule of the scan unit
  typedef enum logic [1:0] {
    SCAN_OLDEST,
    SCAN_NEWEST,
    SCAN_LRU,
    SCAN_NEXT
  } scan_mode_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_SCAN,
    ST_SETTLE,
    ST_EVAL,
    ST_WRITE,
    ST_EMIT
  } state_t;

  // one table row as read back from the store
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   pay;
    logic [STAMP_W-1:0] acc;
    logic [STAMP_W-1:0] ins;
  } row_t;

  // sequencer to scan unit
  typedef struct packed {
    logic               start;
    scan_mode_t         mode;
    logic [KEY_W-1:0]   key;
    logic               have_prev;
    logic [STAMP_W-1:0] prev;
  } scan_ctl_t;

  // scan unit to sequencer
  typedef struct packed {
    logic               found;
    logic [PAY_W-1:0]   pay;
    logic [STAMP_W-1:0] ins;
    logic               free_found;
  } scan_res_t;

endpackage

// ===== rtl/core/kcs_if.sv =====
`timescale 1ns / 1ps
interface kcs_req_if import kcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, output op, output key, output payload, input ready);
  modport sink (input valid, input op, input key, input payload, output ready);
endinterface

interface kcs_rsp_if import kcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [PAY_W-1:0]     payload_out;
  logic                 last;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (
    output valid, output found, output payload_out, output last, output entry_count,
    input ready
  );
  modport sink (
    input valid, input found, input payload_out, input last, input entry_count,
    output ready
  );
endinterface

// ===== rtl/core/keyed_context_store_lru.sv =====
`timescale 1ns / 1ps
// Keyed context store with LRU replacement. Up to MAX_ENTRIES (key, payload) entries are held
// in on-chip memories and found by a scan unit that reads one row per clock, so every push,
// pop, peek and get_all makes at least one pass over all MAX_ENTRIES rows, and in_ch.ready
// is low until the operation's results have gone into the output register. A push makes
// a second pass, to find the least recently used victim, when the table is full and no
// entry of the same key is dropped; get_all makes one pass per result and streams the
// matching entries oldest insertion first; clear is a sweep of the valid memory, and an
// unused op code leaves the table alone. After reset the same sweep runs before the first
// input transfer. Each result reports the entry count modulo 64.
// per_key_limit is written through cfg_we / cfg_wdata and should only change while idle.
`include "keyed_context_store_lru_macros.svh"
module keyed_context_store_lru import kcs_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  kcs_req_if.sink            in_ch,
  kcs_rsp_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

  // sequencer state and the command being worked on
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   sidx_r, sidx_nxt;       // scan address, also the wipe address
  logic               wipe_emit_r, wipe_emit_nxt;
  logic               lru_phase_r, lru_phase_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  scan_mode_t         mode_r, mode_nxt;
  logic [STAMP_W-1:0] prev_r, prev_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic               grow_r, grow_nxt;

  // table-wide state
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [STAMP_W-1:0] acc_cnt_r, acc_cnt_nxt;
  logic [STAMP_W-1:0] ins_cnt_r, ins_cnt_nxt;

  // pending result, then the output register
  logic               res_found_r, res_found_nxt;
  logic [PAY_W-1:0]   res_pay_r, res_pay_nxt;
  logic               res_last_r, res_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [PAY_W-1:0]   out_pay_r;
  logic               out_last_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  // read pipeline from the store into the scan unit
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  row_t               rd_row;

  // store write ports
  logic               vld_we;
  logic [IDX_W-1:0]   vld_addr;
  logic               vld_data;
  logic               ent_we;
  logic               acc_we;
  logic [IDX_W-1:0]   acc_addr;

  // scan unit
  scan_ctl_t          scan_ctl;
  scan_res_t          scan_res;
  logic               scan_start;
  logic [IDX_W-1:0]   best_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [CNT_W-1:0]   elig_cnt;

  logic in_ready;
  logic in_fire;
  logic out_free;
  logic out_load;
  logic drop_oldest;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // per-key limit reached: the oldest entry of the key makes room (with a zero limit, whenever the key has one)
  assign drop_oldest = (CMP_W'(elig_cnt) >= CMP_W'(limit_r)) && scan_res.found;

  assign scan_ctl = '{start: scan_start, mode: mode_r, key: key_r,
                      have_prev: have_prev_r, prev: prev_r};

  kcs_store #(
    .N     (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .rd_addr  (sidx_r),
    .rd_row   (rd_row),
    .vld_we   (vld_we),
    .vld_addr (vld_addr),
    .vld_data (vld_data),
    .ent_we   (ent_we),
    .ent_addr (slot_r),
    .ent_key  (key_r),
    .ent_pay  (pay_r),
    .ent_ins  (ins_cnt_r + 1'b1),
    .acc_we   (acc_we),
    .acc_addr (acc_addr),
    .acc_data (acc_cnt_r + 1'b1)
  );

  kcs_scan #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .row_vld  (rd_vld_r),
    .row      (rd_row),
    .row_idx  (rd_idx_r),
    .res      (scan_res),
    .best_idx (best_idx),
    .free_idx (free_idx),
    .elig_cnt (elig_cnt)
  );

  // sequencer: next state and store / scan controls
  always_comb begin
    state_nxt     = state_r;
    sidx_nxt      = sidx_r;
    wipe_emit_nxt = wipe_emit_r;
    lru_phase_nxt = lru_phase_r;
    have_prev_nxt = have_prev_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    mode_nxt      = mode_r;
    prev_nxt      = prev_r;
    slot_nxt      = slot_r;
    grow_nxt      = grow_r;
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    count_nxt     = count_r;
    acc_cnt_nxt   = acc_cnt_r;
    ins_cnt_nxt   = ins_cnt_r;
    res_found_nxt = res_found_r;
    res_pay_nxt   = res_pay_r;
    res_last_nxt  = res_last_r;
    scan_start    = 1'b0;
    vld_we        = 1'b0;
    vld_addr      = sidx_r;
    vld_data      = 1'b0;
    ent_we        = 1'b0;
    acc_we        = 1'b0;
    acc_addr      = best_idx;
    out_load      = 1'b0;

    unique case (state_r)
      ST_WIPE: begin
        // clearing sweep of the valid memory
        vld_we   = 1'b1;
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == LAST_IDX) begin
          sidx_nxt  = '0;
          state_nxt = wipe_emit_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt        = in_ch.op;
          key_nxt       = in_ch.key;
          pay_nxt       = in_ch.payload;
          have_prev_nxt = 1'b0;
          lru_phase_nxt = 1'b0;
          sidx_nxt      = '0;
          res_found_nxt = 1'b0;
          res_pay_nxt   = '0;
          res_last_nxt  = 1'b1;
          unique case (in_ch.op) inside
            OP_PUSH: begin
              mode_nxt   = SCAN_OLDEST;
              scan_start = 1'b1;
              state_nxt  = ST_SCAN;
            end
            OP_POP, OP_PEEK: begin
              mode_nxt   = SCAN_NEWEST;
              scan_start = 1'b1;
              state_nxt  = ST_SCAN;
            end
            OP_GET_ALL: begin
              mode_nxt   = SCAN_NEXT;
              scan_start = 1'b1;
              state_nxt  = ST_SCAN;
            end
            OP_CLEAR: begin
              count_nxt     = '0;
              acc_cnt_nxt   = '0;
              ins_cnt_nxt   = '0;
              wipe_emit_nxt = 1'b1;
              state_nxt     = ST_WIPE;
            end
            default: begin
              // unused codes leave the table alone
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == LAST_IDX) begin
          sidx_nxt  = '0;
          state_nxt = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        // last row still in flight to the scan unit
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_EMIT;
        unique case (op_r) inside
          OP_PUSH: begin
            state_nxt = ST_WRITE;
            if (lru_phase_r) begin
              // full table: the victim's slot is reused in place
              slot_nxt = best_idx;
              grow_nxt = 1'b0;
            end else if (drop_oldest) begin
              vld_we   = 1'b1;
              vld_addr = best_idx;
              slot_nxt = (scan_res.free_found && (free_idx < best_idx)) ? free_idx : best_idx;
              grow_nxt = 1'b0;
            end else if (count_r == FULL_CNT) begin
              lru_phase_nxt = 1'b1;
              mode_nxt      = SCAN_LRU;
              scan_start    = 1'b1;
              state_nxt     = ST_SCAN;
            end else begin
              slot_nxt = free_idx;
              grow_nxt = 1'b1;
            end
          end
          OP_POP: begin
            if (scan_res.found) begin
              vld_we        = 1'b1;
              vld_addr      = best_idx;
              count_nxt     = count_r - 1'b1;
              res_found_nxt = 1'b1;
              res_pay_nxt   = scan_res.pay;
            end
          end
          OP_PEEK: begin
            if (scan_res.found) begin
              acc_we        = 1'b1;
              acc_cnt_nxt   = acc_cnt_r + 1'b1;
              res_found_nxt = 1'b1;
              res_pay_nxt   = scan_res.pay;
            end
          end
          OP_GET_ALL: begin
            // the pass also counts what is left, so the final transfer is known here
            if (scan_res.found) begin
              res_found_nxt = 1'b1;
              res_pay_nxt   = scan_res.pay;
              res_last_nxt  = (elig_cnt == CNT_W'(1));
              prev_nxt      = scan_res.ins;
              have_prev_nxt = 1'b1;
            end
          end
          default: begin
            state_nxt = ST_EMIT;
          end
        endcase
      end
      ST_WRITE: begin
        // append the pushed entry with fresh access and insertion stamps
        vld_we      = 1'b1;
        vld_addr    = slot_r;
        vld_data    = 1'b1;
        ent_we      = 1'b1;
        acc_we      = 1'b1;
        acc_addr    = slot_r;
        acc_cnt_nxt = acc_cnt_r + 1'b1;
        ins_cnt_nxt = ins_cnt_r + 1'b1;
        if (grow_r) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          wipe_emit_nxt = 1'b0;
          if (res_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            // next entry of the get_all stream
            sidx_nxt   = '0;
            scan_start = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      sidx_r      <= '0;
      wipe_emit_r <= 1'b0;
      lru_phase_r <= 1'b0;
      have_prev_r <= 1'b0;
      mode_r      <= SCAN_OLDEST;
      limit_r     <= LIMIT_RST;
      count_r     <= '0;
      acc_cnt_r   <= '0;
      ins_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sidx_r      <= sidx_nxt;
      wipe_emit_r <= wipe_emit_nxt;
      lru_phase_r <= lru_phase_nxt;
      have_prev_r <= have_prev_nxt;
      mode_r      <= mode_nxt;
      limit_r     <= limit_nxt;
      count_r     <= count_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      ins_cnt_r   <= ins_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    pay_r       <= pay_nxt;
    prev_r      <= prev_nxt;
    slot_r      <= slot_nxt;
    grow_r      <= grow_nxt;
    res_found_r <= res_found_nxt;
    res_pay_r   <= res_pay_nxt;
    res_last_r  <= res_last_nxt;
    rd_idx_r    <= sidx_r;
    if (out_load) begin
      out_found_r <= res_found_r;
      out_pay_r   <= res_pay_r;
      out_last_r  <= res_last_r;
      out_cnt_r   <= CNT_OUT_W'(count_r);
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.payload_out = out_pay_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.entry_count = out_cnt_r;

  // occupancy never passes the table size
  `KCS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= FULL_CNT)
  // only get_all hits are followed by further transfers
  `KCS_ASSERT_IMP(a_stream_found, out_ch.valid && !out_ch.last, out_ch.found)
  // rows reach the scan unit only from a running pass
  `KCS_ASSERT_IMP(a_rd_in_scan, rd_vld_r, state_r == ST_SCAN || state_r == ST_SETTLE)
  // an lru pass is only started on a full table
  `KCS_ASSERT_IMP(a_lru_full, state_r == ST_EVAL && op_r == OP_PUSH && lru_phase_r,
                  count_r == FULL_CNT)
  // the wipe leaves the table empty
  `KCS_ASSERT_NXT(a_wipe_empty, state_r == ST_WIPE, count_r == '0)

endmodule

// ===== rtl/core/kcs_store.sv =====
`timescale 1ns / 1ps
module kcs_store import kcs_pkg::*; #(
  parameter int N     = 32,
  parameter int IDX_W = 5
) (
  input  logic               clk,
  input  logic [IDX_W-1:0]   rd_addr,
  output row_t               rd_row,
  input  logic               vld_we,
  input  logic [IDX_W-1:0]   vld_addr,
  input  logic               vld_data,
  input  logic               ent_we,
  input  logic [IDX_W-1:0]   ent_addr,
  input  logic [KEY_W-1:0]   ent_key,
  input  logic [PAY_W-1:0]   ent_pay,
  input  logic [STAMP_W-1:0] ent_ins,
  input  logic               acc_we,
  input  logic [IDX_W-1:0]   acc_addr,
  input  logic [STAMP_W-1:0] acc_data
);

  logic               vld_mem [N];
  logic [KEY_W-1:0]   key_mem [N];
  logic [PAY_W-1:0]   pay_mem [N];
  logic [STAMP_W-1:0] acc_mem [N];
  logic [STAMP_W-1:0] ins_mem [N];

  logic               rd_vld_r;
  logic [KEY_W-1:0]   rd_key_r;
  logic [PAY_W-1:0]   rd_pay_r;
  logic [STAMP_W-1:0] rd_acc_r;
  logic [STAMP_W-1:0] rd_ins_r;

  always_ff @(posedge clk) begin
    if (vld_we) begin
      vld_mem[vld_addr] <= vld_data;
    end
    rd_vld_r <= vld_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[ent_addr] <= ent_key;
    end
    rd_key_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      pay_mem[ent_addr] <= ent_pay;
    end
    rd_pay_r <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ins_mem[ent_addr] <= ent_ins;
    end
    rd_ins_r <= ins_mem[rd_addr];
  end

  // access stamps are also refreshed on their own by peek
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_data;
    end
    rd_acc_r <= acc_mem[rd_addr];
  end

  assign rd_row = '{vld: rd_vld_r, key: rd_key_r, pay: rd_pay_r, acc: rd_acc_r, ins: rd_ins_r};

endmodule

// ===== rtl/core/kcs_scan.sv =====
`timescale 1ns / 1ps
module kcs_scan import kcs_pkg::*; #(
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_ctl_t        ctl,
  input  logic             row_vld,
  input  row_t             row,
  input  logic [IDX_W-1:0] row_idx,
  output scan_res_t        res,
  output logic [IDX_W-1:0] best_idx,
  output logic [IDX_W-1:0] free_idx,
  output logic [CNT_W-1:0] elig_cnt
);

  logic               found_r;
  logic               free_found_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [PAY_W-1:0]   best_pay_r;
  logic [STAMP_W-1:0] best_ins_r;
  logic [STAMP_W-1:0] best_acc_r;

  logic match;
  logic ins_lt;
  logic elig;
  logic better;
  logic take;

  always_comb begin
    match  = row.vld && (row.key == ctl.key);
    ins_lt = row.ins < best_ins_r;
    unique case (ctl.mode)
      SCAN_OLDEST: begin
        elig   = match;
        better = ins_lt;
      end
      SCAN_NEWEST: begin
        elig   = match;
        better = row.ins > best_ins_r;
      end
      SCAN_LRU: begin
        // ties on access stamp go to the earlier insertion
        elig   = row.vld;
        better = (row.acc < best_acc_r) || ((row.acc == best_acc_r) && ins_lt);
      end
      SCAN_NEXT: begin
        elig   = match && (!ctl.have_prev || (row.ins > ctl.prev));
        better = ins_lt;
      end
    endcase
    take = row_vld && elig && (!found_r || better);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      cnt_r        <= '0;
    end else if (row_vld) begin
      if (take) begin
        found_r <= 1'b1;
      end
      if (elig) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (!row.vld) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= row_idx;
      best_pay_r <= row.pay;
      best_ins_r <= row.ins;
      best_acc_r <= row.acc;
    end
    if (row_vld && !row.vld && !free_found_r) begin
      free_idx_r <= row_idx;
    end
  end

  assign res      = '{found: found_r, pay: best_pay_r, ins: best_ins_r, free_found: free_found_r};
  assign best_idx = best_idx_r;
  assign free_idx = free_idx_r;
  assign elig_cnt = cnt_r;

endmodule
